FILE: rtl/segregated_fit_heap_allocator_assert.svh
// assertion macros for the segregated fit heap allocator
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SFH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfh assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SFH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfh assertion failed");

`endif

FILE: rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// constants, state codes, types and helpers shared by the heap allocator
// ----------------------------------------------------------------------------
package sfh_pkg;

    // arena geometry
    localparam int ARENA_BYTES  = 65536;
    localparam int ARENA_WORDS  = ARENA_BYTES / 8;
    localparam int ADDR_W       = 16;
    localparam int WIDX_W       = 13;
    localparam int BUCKET_COUNT = 16;
    localparam int BKT_W        = 4;
    localparam int SIZE_W       = 17;
    localparam int STEP_W       = 14;

    localparam logic [ADDR_W-1:0] BIT_ALLOC = 16'h0001;
    localparam logic [ADDR_W-1:0] BIT_PREV  = 16'h0002;
    localparam logic [ADDR_W-1:0] SZ_MASK   = 16'hFFFC;
    localparam logic [SIZE_W-1:0] MIN_SPLIT = 17'd32;
    localparam logic [ADDR_W-1:0] FIRST_BLK = 16'd24;
    localparam logic [ADDR_W-1:0] EPI_OFF   = 16'(ARENA_BYTES - 24);
    localparam logic [ADDR_W-1:0] FREE_SZ   = 16'(ARENA_BYTES - 48);
    localparam logic [ADDR_W-1:0] TAG_SZ    = 16'd24;
    localparam logic [STEP_W-1:0] MAX_STEPS = 14'(ARENA_WORDS);

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_IGN  = 2'd3;

    // sequencer state codes, also the datapath step command
    typedef logic [5:0] t_state;
    localparam t_state S_CLR   = 6'd0;
    localparam t_state S_INIT0 = 6'd1;
    localparam t_state S_INIT1 = 6'd2;
    localparam t_state S_INIT2 = 6'd3;
    localparam t_state S_INIT3 = 6'd4;
    localparam t_state S_IDLE  = 6'd5;
    localparam t_state S_FHEAD = 6'd6;
    localparam t_state S_FH    = 6'd7;
    localparam t_state S_FN    = 6'd8;
    localparam t_state S_U0    = 6'd9;
    localparam t_state S_U1    = 6'd10;
    localparam t_state S_U2    = 6'd11;
    localparam t_state S_U3    = 6'd12;
    localparam t_state S_U4    = 6'd13;
    localparam t_state S_ARD   = 6'd14;
    localparam t_state S_AH    = 6'd15;
    localparam t_state S_SH    = 6'd16;
    localparam t_state S_SF    = 6'd17;
    localparam t_state S_NR    = 6'd18;
    localparam t_state S_NH    = 6'd19;
    localparam t_state S_NF    = 6'd20;
    localparam t_state S_M0    = 6'd21;
    localparam t_state S_M1    = 6'd22;
    localparam t_state S_M2    = 6'd23;
    localparam t_state S_M3    = 6'd24;
    localparam t_state S_M4    = 6'd25;
    localparam t_state S_M5    = 6'd26;
    localparam t_state S_M6    = 6'd27;
    localparam t_state S_M7    = 6'd28;
    localparam t_state S_M8    = 6'd29;
    localparam t_state S_L0    = 6'd30;
    localparam t_state S_L1    = 6'd31;
    localparam t_state S_L2    = 6'd32;
    localparam t_state S_WCHK  = 6'd33;
    localparam t_state S_WS    = 6'd34;
    localparam t_state S_WT    = 6'd35;
    localparam t_state S_WTF   = 6'd36;
    localparam t_state S_DONE  = 6'd37;

    // controller to datapath
    typedef struct packed {
        t_state op;
        logic   load;
        logic   push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_free;
        logic in_zero;
        logic in_null;
        logic is_free;
        logic clr_last;
        logic head_go;
        logic bkt_last;
        logic fit;
        logic next_go;
        logic no_split;
        logic rd_bit0;
        logic rd_bit1;
        logic mb_epi;
        logic cur_end;
        logic cur_hit;
        logic step_bad;
    } t_flags;

    // one result word
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] paddr;
        logic [SIZE_W-1:0] bytes;
    } t_result;

    // size field of a tag word
    function automatic logic [ADDR_W-1:0] sz(input logic [ADDR_W-1:0] h);
        return h & SZ_MASK;
    endfunction

    // word index of a byte offset, wraps modulo the arena
    function automatic logic [WIDX_W-1:0] wi(input logic [ADDR_W-1:0] b);
        return b[ADDR_W-1:3];
    endfunction

    // free-list bucket of a block size
    function automatic logic [BKT_W-1:0] bucket_of(input logic [SIZE_W-1:0] s);
        logic [4:0] msb;
        msb = 5'd0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (s[i]) msb = 5'(i);
        end
        if (s <= 17'd32) return '0;
        if (msb <= 5'd5) return '0;
        if ((msb - 5'd5) >= 5'(BUCKET_COUNT - 1)) return BKT_W'(BUCKET_COUNT - 1);
        return BKT_W'(msb - 5'd5);
    endfunction

    localparam logic [BKT_W-1:0] FIRST_BKT = bucket_of({1'b0, FREE_SZ});

endpackage

FILE: rtl/sfh_req_if.sv
// ----------------------------------------------------------------------------
// sfh_req_if
// request channel: allocate or free word with valid/ready
// ----------------------------------------------------------------------------
interface sfh_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] req_size;
    logic [15:0] free_addr;

    modport source (output valid, output cmd, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input cmd, input req_size, input free_addr,
                    output ready);
endinterface

FILE: rtl/sfh_rsp_if.sv
// ----------------------------------------------------------------------------
// sfh_rsp_if
// response channel: one result word per request with valid/ready
// ----------------------------------------------------------------------------
interface sfh_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] payload_addr;
    logic [16:0] block_bytes;

    modport source (output valid, output status, output payload_addr,
                    output block_bytes, input ready);
    modport sink   (input valid, input status, input payload_addr,
                    input block_bytes, output ready);
endinterface

FILE: rtl/sfh_ctrl.sv
// ----------------------------------------------------------------------------
// sfh_ctrl
// sequencer: walks the allocate, free, unlink, merge and link-in steps
// ----------------------------------------------------------------------------
module sfh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  sfh_pkg::t_flags i_flags,
    output sfh_pkg::t_cmd   o_cmd,
    output logic          o_in_ready
);
    import sfh_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // step command to the datapath
    always_comb begin
        o_cmd.op   = r_state;
        o_cmd.load = accept;
        o_cmd.push = (r_state == S_DONE) && i_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_CLR:   if (i_flags.clr_last) n_state = S_INIT0;
            S_INIT0: n_state = S_INIT1;
            S_INIT1: n_state = S_INIT2;
            S_INIT2: n_state = S_INIT3;
            S_INIT3: n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (!i_flags.in_free) n_state = i_flags.in_zero ? S_DONE : S_FHEAD;
                    else                  n_state = i_flags.in_null ? S_DONE : S_WCHK;
                end
            end
            S_FHEAD: begin
                if (i_flags.head_go)       n_state = S_FH;
                else if (i_flags.bkt_last) n_state = S_DONE;
            end
            S_FH: begin
                if (i_flags.fit) begin
                    n_state = S_U0;
                    n_ret   = S_ARD;
                end else begin
                    n_state = S_FN;
                end
            end
            S_FN: begin
                if (i_flags.next_go)       n_state = S_FH;
                else if (i_flags.bkt_last) n_state = S_DONE;
                else                       n_state = S_FHEAD;
            end
            S_U0:  n_state = S_U1;
            S_U1:  n_state = S_U2;
            S_U2:  n_state = S_U3;
            S_U3:  n_state = S_U4;
            S_U4:  n_state = r_ret;
            S_ARD: n_state = S_AH;
            S_AH:  n_state = i_flags.no_split ? S_NR : S_SH;
            S_SH:  n_state = S_SF;
            S_SF:  n_state = S_M0;
            S_NR:  n_state = S_NH;
            S_NH: begin
                if (!i_flags.rd_bit0)     n_state = S_NF;
                else if (i_flags.is_free) n_state = S_M0;
                else                      n_state = S_DONE;
            end
            S_NF:  n_state = i_flags.is_free ? S_M0 : S_DONE;
            S_M0:  n_state = S_M1;
            S_M1:  n_state = i_flags.rd_bit1 ? S_M4 : S_M2;
            S_M2:  n_state = S_M3;
            S_M3: begin
                n_state = S_U0;
                n_ret   = S_M4;
            end
            S_M4:  n_state = i_flags.mb_epi ? S_M6 : S_M5;
            S_M5: begin
                if (!i_flags.rd_bit0) begin
                    n_state = S_U0;
                    n_ret   = S_M6;
                end else begin
                    n_state = S_M6;
                end
            end
            S_M6:  n_state = S_M7;
            S_M7:  n_state = S_M8;
            S_M8:  n_state = S_L0;
            S_L0:  n_state = S_L1;
            S_L1:  n_state = S_L2;
            S_L2:  n_state = S_DONE;
            S_WCHK: begin
                if (i_flags.cur_end)      n_state = S_DONE;
                else if (i_flags.cur_hit) n_state = S_WT;
                else                      n_state = S_WS;
            end
            S_WS:  n_state = i_flags.step_bad ? S_DONE : S_WCHK;
            S_WT:  n_state = i_flags.rd_bit0 ? S_WTF : S_DONE;
            S_WTF: n_state = S_NR;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

FILE: rtl/sfh_dpath.sv
// ----------------------------------------------------------------------------
// sfh_dpath
// arena memory, bucket heads and working registers, stepped by the sequencer
// ----------------------------------------------------------------------------
module sfh_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfh_pkg::t_cmd                 i_cmd,
    input  logic                          i_in_cmd,
    input  logic [sfh_pkg::ADDR_W-1:0]    i_in_size,
    input  logic [sfh_pkg::ADDR_W-1:0]    i_in_addr,
    output sfh_pkg::t_flags               o_flags,
    output sfh_pkg::t_result              o_result
);
    import sfh_pkg::*;

    // arena and free-list heads
    logic [ADDR_W-1:0] r_mem [ARENA_WORDS];
    logic [ADDR_W-1:0] r_heads [BUCKET_COUNT];
    logic [ADDR_W-1:0] r_rdata;

    // working registers
    logic [WIDX_W-1:0] r_clr, n_clr;
    logic              r_is_free, n_is_free;
    logic [SIZE_W-1:0] r_need, n_need;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [ADDR_W-1:0] r_b, n_b;
    logic [ADDR_W-1:0] r_pb, n_pb;
    logic [ADDR_W-1:0] r_ph, n_ph;
    logic [ADDR_W-1:0] r_mb, n_mb;
    logic [ADDR_W-1:0] r_ms, n_ms;
    logic [ADDR_W-1:0] r_mn, n_mn;
    logic [ADDR_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_ub, n_ub;
    logic [ADDR_W-1:0] r_up, n_up;
    logic [ADDR_W-1:0] r_un, n_un;
    t_result           r_res, n_res;

    // memory port and head write port
    logic              mem_we, mem_re;
    logic [WIDX_W-1:0] mem_idx;
    logic [ADDR_W-1:0] mem_wdata;
    logic              head_we;
    logic [BKT_W-1:0]  head_widx;
    logic [ADDR_W-1:0] head_wdata;
    logic [BKT_W-1:0]  head_ridx;
    logic [ADDR_W-1:0] head_rd;

    // derived values
    logic [SIZE_W-1:0] in_clamp, in_round;
    logic [ADDR_W-1:0] rd_sz;
    logic [SIZE_W-1:0] rest;
    logic [SIZE_W-1:0] walk_sum;
    logic [STEP_W-1:0] steps_inc;
    logic [ADDR_W-1:0] tag_val;

    assign rd_sz     = sz(r_rdata);
    assign in_clamp  = (i_in_size < 16'd32) ? 17'd32 : {1'b0, i_in_size};
    assign in_round  = (in_clamp + 17'd23) & ~17'd15;
    assign rest      = {1'b0, rd_sz} - r_need;
    assign walk_sum  = {1'b0, r_cur} + {1'b0, rd_sz};
    assign steps_inc = r_steps + 14'd1;
    assign head_ridx = (i_cmd.op == S_FHEAD) ? r_bkt : bucket_of({1'b0, r_ms});
    assign head_rd   = r_heads[head_ridx];
    assign tag_val   = rd_sz | (r_rdata & BIT_ALLOC) | (r_is_free ? 16'd0 : BIT_PREV);

    // status to the sequencer
    always_comb begin
        o_flags.in_free  = i_in_cmd;
        o_flags.in_zero  = (i_in_size == 16'd0);
        o_flags.in_null  = (i_in_addr < 16'd8);
        o_flags.is_free  = r_is_free;
        o_flags.clr_last = (r_clr == WIDX_W'(ARENA_WORDS - 1));
        o_flags.head_go  = (head_rd != 16'd0) && (r_steps != MAX_STEPS);
        o_flags.bkt_last = (r_bkt == BKT_W'(BUCKET_COUNT - 1));
        o_flags.fit      = !r_rdata[0] && ({1'b0, rd_sz} >= r_need);
        o_flags.next_go  = (r_rdata != 16'd0) && (steps_inc < MAX_STEPS);
        o_flags.no_split = (rest < MIN_SPLIT);
        o_flags.rd_bit0  = r_rdata[0];
        o_flags.rd_bit1  = r_rdata[1];
        o_flags.mb_epi   = (r_mb == EPI_OFF);
        o_flags.cur_end  = (r_cur >= EPI_OFF);
        o_flags.cur_hit  = (r_cur == r_b);
        o_flags.step_bad = (rd_sz < 16'd16) || (walk_sum >= {1'b0, EPI_OFF});
    end

    assign o_result = r_res;

    // step actions
    always_comb begin
        n_clr = r_clr;     n_is_free = r_is_free; n_need = r_need;  n_bkt = r_bkt;
        n_steps = r_steps; n_cur = r_cur;         n_b = r_b;        n_pb = r_pb;
        n_ph = r_ph;       n_mb = r_mb;           n_ms = r_ms;      n_mn = r_mn;
        n_start = r_start; n_ub = r_ub;           n_up = r_up;      n_un = r_un;
        n_res = r_res;
        mem_we = 1'b0; mem_re = 1'b0; mem_idx = '0; mem_wdata = '0;
        head_we = 1'b0; head_widx = '0; head_wdata = '0;
        case (i_cmd.op)
            // clearing pass and arena format
            S_CLR: begin
                mem_we = 1'b1; mem_idx = r_clr; n_clr = r_clr + 13'd1;
            end
            S_INIT0: begin
                mem_we = 1'b1; mem_idx = wi(16'd0); mem_wdata = TAG_SZ | BIT_ALLOC | BIT_PREV;
            end
            S_INIT1: begin
                mem_we = 1'b1; mem_idx = wi(FIRST_BLK); mem_wdata = FREE_SZ | BIT_PREV;
            end
            S_INIT2: begin
                mem_we = 1'b1; mem_idx = wi(16'(FIRST_BLK + FREE_SZ - 16'd8));
                mem_wdata = FREE_SZ | BIT_PREV;
            end
            S_INIT3: begin
                mem_we = 1'b1; mem_idx = wi(EPI_OFF); mem_wdata = TAG_SZ | BIT_ALLOC;
            end
            // take a request word
            S_IDLE: begin
                if (i_cmd.load) begin
                    n_is_free = i_in_cmd;
                    n_need    = in_round;
                    n_bkt     = bucket_of(in_round);
                    n_steps   = '0;
                    n_cur     = FIRST_BLK;
                    n_b       = i_in_addr - 16'd8;
                    n_res     = '0;
                    if (!i_in_cmd && (i_in_size == 16'd0)) n_res.status = ST_ZERO;
                    if (i_in_cmd && (i_in_addr < 16'd8))   n_res.status = ST_IGN;
                end
            end
            // first fit over the buckets
            S_FHEAD: begin
                n_cur = head_rd;
                if (o_flags.head_go) begin
                    mem_re = 1'b1; mem_idx = wi(head_rd);
                end else if (!o_flags.bkt_last) begin
                    n_bkt = r_bkt + 4'd1;
                end else begin
                    n_res.status = ST_OOM;
                end
            end
            S_FH: begin
                if (o_flags.fit) begin
                    n_b = r_cur; n_ub = r_cur;
                end else begin
                    mem_re = 1'b1; mem_idx = wi(16'(r_cur + 16'd16));
                end
            end
            S_FN: begin
                n_cur   = r_rdata;
                n_steps = steps_inc;
                if (o_flags.next_go) begin
                    mem_re = 1'b1; mem_idx = wi(r_rdata);
                end else if (!o_flags.bkt_last) begin
                    n_bkt = r_bkt + 4'd1;
                end else begin
                    n_res.status = ST_OOM;
                end
            end
            // unlink r_ub from its list
            S_U0: begin
                mem_re = 1'b1; mem_idx = wi(16'(r_ub + 16'd8));
            end
            S_U1: begin
                n_up = r_rdata; mem_re = 1'b1; mem_idx = wi(16'(r_ub + 16'd16));
            end
            S_U2: begin
                n_un = r_rdata; mem_re = 1'b1; mem_idx = wi(r_ub);
            end
            S_U3: begin
                if (r_up != 16'd0) begin
                    mem_we = 1'b1; mem_idx = wi(16'(r_up + 16'd16)); mem_wdata = r_un;
                end else begin
                    head_we = 1'b1; head_widx = bucket_of({1'b0, rd_sz}); head_wdata = r_un;
                end
            end
            S_U4: begin
                if (r_un != 16'd0) begin
                    mem_we = 1'b1; mem_idx = wi(16'(r_un + 16'd8)); mem_wdata = r_up;
                end
            end
            // grant, with or without split
            S_ARD: begin
                mem_re = 1'b1; mem_idx = wi(r_b);
            end
            S_AH: begin
                mem_we      = 1'b1;
                mem_idx     = wi(r_b);
                n_res.paddr = 16'(r_b + 16'd8);
                if (o_flags.no_split) begin
                    mem_wdata   = rd_sz | BIT_ALLOC | (r_rdata & BIT_PREV);
                    n_res.bytes = {1'b0, rd_sz};
                    n_pb        = 16'(r_b + rd_sz);
                end else begin
                    mem_wdata   = r_need[ADDR_W-1:0] | BIT_ALLOC | (r_rdata & BIT_PREV);
                    n_res.bytes = r_need;
                    n_pb        = 16'(r_b + r_need[ADDR_W-1:0]);
                    n_ph        = rest[ADDR_W-1:0] | BIT_PREV;
                end
            end
            S_SH: begin
                mem_we = 1'b1; mem_idx = wi(r_pb); mem_wdata = r_ph;
            end
            S_SF: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_pb + sz(r_ph) - 16'd8)); mem_wdata = r_ph;
                n_mb = r_pb;
            end
            // retag the following block
            S_NR: begin
                mem_re = 1'b1; mem_idx = wi(r_pb);
            end
            S_NH: begin
                n_ph = tag_val; mem_we = 1'b1; mem_idx = wi(r_pb); mem_wdata = tag_val;
                n_mb = r_b;
            end
            S_NF: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_pb + sz(r_ph) - 16'd8)); mem_wdata = r_ph;
                n_mb = r_b;
            end
            // merge with free neighbours
            S_M0: begin
                mem_re = 1'b1; mem_idx = wi(r_mb);
            end
            S_M1: begin
                n_ms = rd_sz; n_mn = 16'(r_mb + rd_sz); n_start = r_mb;
                if (!r_rdata[1]) begin
                    mem_re = 1'b1; mem_idx = wi(16'(r_mb - 16'd8));
                end
            end
            S_M2: begin
                n_start = 16'(r_mb - rd_sz);
                mem_re = 1'b1; mem_idx = wi(16'(r_mb - rd_sz));
            end
            S_M3: begin
                n_ms = 16'(r_ms + rd_sz); n_ub = r_start;
            end
            S_M4: begin
                if (!o_flags.mb_epi) begin
                    mem_re = 1'b1; mem_idx = wi(r_mn);
                end
            end
            S_M5: begin
                if (!r_rdata[0]) begin
                    n_ms = 16'(r_ms + rd_sz); n_ub = r_mn;
                end
            end
            S_M6: begin
                mem_re = 1'b1; mem_idx = wi(r_start);
            end
            S_M7: begin
                n_ph = r_ms | (r_rdata & BIT_PREV);
                mem_we = 1'b1; mem_idx = wi(r_start); mem_wdata = r_ms | (r_rdata & BIT_PREV);
            end
            S_M8: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_start + r_ms - 16'd8)); mem_wdata = r_ph;
            end
            // link in at the head of its bucket
            S_L0: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_start + 16'd16)); mem_wdata = head_rd;
            end
            S_L1: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_start + 16'd8));
            end
            S_L2: begin
                if (head_rd != 16'd0) begin
                    mem_we = 1'b1; mem_idx = wi(16'(head_rd + 16'd8)); mem_wdata = r_start;
                end
                head_we = 1'b1; head_widx = head_ridx; head_wdata = r_start;
            end
            // block walk that checks a free address
            S_WCHK: begin
                if (o_flags.cur_end) n_res.status = ST_IGN;
                else begin
                    mem_re = 1'b1; mem_idx = wi(r_cur);
                end
            end
            S_WS: begin
                if (o_flags.step_bad) n_res.status = ST_IGN;
                else                  n_cur = walk_sum[ADDR_W-1:0];
            end
            S_WT: begin
                if (r_rdata[0]) begin
                    n_ph = rd_sz | (r_rdata & BIT_PREV);
                    mem_we = 1'b1; mem_idx = wi(r_b); mem_wdata = rd_sz | (r_rdata & BIT_PREV);
                end else begin
                    n_res.status = ST_IGN;
                end
            end
            S_WTF: begin
                mem_we = 1'b1; mem_idx = wi(16'(r_b + sz(r_ph) - 16'd8)); mem_wdata = r_ph;
                n_pb = 16'(r_b + sz(r_ph));
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // arena port, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_idx] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_idx];
    end

    // bucket heads, reset to the formatted arena
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUCKET_COUNT; k++) begin
                r_heads[k] <= (BKT_W'(k) == FIRST_BKT) ? FIRST_BLK : 16'd0;
            end
        end else if (head_we) begin
            r_heads[head_widx] <= head_wdata;
        end
    end

    // clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else          r_clr <= n_clr;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_is_free <= n_is_free; r_need <= n_need; r_bkt <= n_bkt; r_steps <= n_steps;
        r_cur <= n_cur; r_b <= n_b; r_pb <= n_pb; r_ph <= n_ph;
        r_mb <= n_mb; r_ms <= n_ms; r_mn <= n_mn; r_start <= n_start;
        r_ub <= n_ub; r_up <= n_up; r_un <= n_un; r_res <= n_res;
    end

endmodule

FILE: rtl/segregated_fit_heap_allocator.sv
// a zero size or null free goes straight to its result word; an allocate visits
//   buckets and passes over free-list entries, then grants the entry taken;
//   a free walks blocks from the arena start, then frees the block
// one request at a time: no new request is taken until the last result word is pushed
// reset: a clearing pass over every arena word plus 4 format writes, no request taken until it ends
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator
// boundary-tag heap with segregated free lists: sequencer, datapath, result register
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfh_req_if.sink    i_req,
    sfh_rsp_if.source  o_rsp
);
    import sfh_pkg::*;

    `include "segregated_fit_heap_allocator_assert.svh"

    t_cmd    cmd;
    t_flags  flags;
    t_result res;
    logic    out_free;
    logic    r_ov;
    t_result r_out;

    assign out_free = !r_ov || o_rsp.ready;

    // sequencer
    sfh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_cmd      (cmd),
        .o_in_ready (i_req.ready)
    );

    // datapath
    sfh_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_cmd  (i_req.cmd),
        .i_in_size (i_req.req_size),
        .i_in_addr (i_req.free_addr),
        .o_flags   (flags),
        .o_result  (res)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_ov <= 1'b0;
        else if (cmd.push)     r_ov <= 1'b1;
        else if (o_rsp.ready)  r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (cmd.push) r_out <= res;
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.payload_addr = r_out.paddr;
    assign o_rsp.block_bytes  = r_out.bytes;

    // checks
    `SFH_ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `SFH_ASSERT_IMPL(a_grant_ok, o_rsp.valid && (o_rsp.block_bytes != 17'd0), o_rsp.status == ST_OK)
    `SFH_ASSERT_IMPL(a_fail_no_addr, o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.payload_addr == 16'd0)

endmodule
